@@ hw/rtl/bpr_pkg.sv @@
// shared types and constants for the binomial pyramid reduce block
package bpr_pkg;

  localparam int LINE_DEPTH_DEFAULT = 4096;
  localparam int REG_W              = 13;
  localparam int PIX_W              = 8;
  localparam int SUM_W              = 10;
  localparam int ROW_W              = 12;
  localparam int HEIGHT_LIMIT       = 4096;
  localparam int CFG_INDEX_W        = 1;

  localparam logic [REG_W-1:0] WIDTH_RESET  = REG_W'(640);
  localparam logic [REG_W-1:0] HEIGHT_RESET = REG_W'(480);
  localparam logic [SUM_W-1:0] SUM_MAX      = {SUM_W{1'b1}};

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // what a pixel does to its line buffer entry
  typedef enum logic [1:0] {
    ROW_PAD,
    ROW_CLOSE,
    ROW_ADD
  } row_op_t;

  // what a finished vertical sum does in the horizontal filter
  typedef enum logic [1:0] {
    COL_PAD,
    COL_LEFT,
    COL_CENTRE,
    COL_EMIT
  } col_op_t;

  typedef struct packed {
    logic [SUM_W-1:0] vsum;
    col_op_t          col_op;
    logic             last;
  } queue_entry_t;

endpackage

@@ hw/rtl/binomial_pyramid_reduce.sv @@
// top level of the binomial 2x pyramid reduce block
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------
//  input    | push / full            | pixel_in[7:0]
//  result   | empty / pop            | pixel_out[7:0], frame_last
//  config   | cfg_write              | cfg_index, cfg_data[12:0]
//
// one pixel per cycle back to back while full is low; after the accept of the item
// that closes its window, an output goes through stage, queue and output reg
// reset clears counters, window sums and the queue; the line buffer is not cleared,
// so items are taken from the first cycle after reset
// a stalled result holds the output register while the four-entry queue fills;
// full rises once the queue and the line buffer stage hold four items between them
module binomial_pyramid_reduce #(
  parameter int LINE_DEPTH = bpr_pkg::LINE_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [bpr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bpr_pkg::REG_W-1:0]         cfg_data,
  input  logic                              push,
  output logic                              full,
  input  logic [bpr_pkg::PIX_W-1:0]         pixel_in,
  output logic                              empty,
  input  logic                              pop,
  output logic [bpr_pkg::PIX_W-1:0]         pixel_out,
  output logic                              frame_last
);

  logic                        q_push;
  bpr_pkg::queue_entry_t       q_entry;
  logic                        q_pop;
  logic                        q_valid;
  bpr_pkg::queue_entry_t       q_head;
  logic [bpr_pkg::QCNT_W-1:0]  q_count;

  bpr_front #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .pixel_in  (pixel_in),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  bpr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_entry (q_entry),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_entry (q_head),
    .count    (q_count)
  );

  bpr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .pixel_out  (pixel_out),
    .frame_last (frame_last)
  );

endmodule

@@ hw/rtl/bpr_queue.sv @@
// short queue of vertical sums between the front and back parts
module bpr_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  bpr_pkg::queue_entry_t        wr_entry,
  input  logic                         rd_en,
  output logic                         rd_valid,
  output bpr_pkg::queue_entry_t        rd_entry,
  output logic [bpr_pkg::QCNT_W-1:0]   count
);

  bpr_pkg::queue_entry_t slots [bpr_pkg::QUEUE_DEPTH];
  logic [bpr_pkg::QPTR_W-1:0] wr_ptr;
  logic [bpr_pkg::QPTR_W-1:0] rd_ptr;

  assign rd_valid = (count != '0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en && rd_valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en && rd_valid})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (count < bpr_pkg::QCNT_W'(bpr_pkg::QUEUE_DEPTH)))
    else $error("queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bpr_pkg::QCNT_W'(bpr_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

@@ hw/rtl/bpr_front.sv @@
// front part: registers, raster counters, line buffer and vertical filter
module bpr_front #(
  parameter int LINE_DEPTH = bpr_pkg::LINE_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [bpr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bpr_pkg::REG_W-1:0]         cfg_data,
  input  logic                              push,
  output logic                              full,
  input  logic [bpr_pkg::PIX_W-1:0]         pixel_in,
  input  logic [bpr_pkg::QCNT_W-1:0]        q_count,
  output logic                              q_push,
  output bpr_pkg::queue_entry_t             q_entry
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int CW = (AW + 1 > bpr_pkg::REG_W) ? AW + 1 : bpr_pkg::REG_W;
  localparam int SW = bpr_pkg::SUM_W;
  localparam int PW = bpr_pkg::PIX_W;
  localparam int RW = bpr_pkg::ROW_W;

  logic [bpr_pkg::REG_W-1:0] image_width;
  logic [bpr_pkg::REG_W-1:0] image_height;
  logic [AW-1:0]             column_count;
  logic [RW-1:0]             row_count;

  logic [AW-1:0] w_last;
  logic [RW-1:0] h_last;
  logic [AW-1:0] x;
  logic [RW-1:0] y;
  logic          xoff;
  logic          yoff;
  logic          accept;
  logic [bpr_pkg::QCNT_W:0] credit;

  bpr_pkg::row_op_t row_op;
  logic             have_v;
  bpr_pkg::col_op_t col_op;
  logic             is_last;

  // one stage after accept: line buffer read data lands here
  logic             stage_valid;
  logic [PW-1:0]    stage_pixel;
  logic [AW-1:0]    stage_x;
  bpr_pkg::row_op_t stage_row_op;
  logic             stage_have_v;
  bpr_pkg::col_op_t stage_col_op;
  logic             stage_last;
  logic [SW-1:0]    line_rd;

  logic [SW-1:0]    line_mem [LINE_DEPTH];
  logic [SW-1:0]    buf_next;
  logic [SW-1:0]    vsum;
  logic [SW:0]      sum_close;
  logic [SW:0]      sum_add;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bpr_pkg::WIDTH_RESET;
      image_height <= bpr_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (bpr_pkg::cfg_reg_t'(cfg_index))
        bpr_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        bpr_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the registers to their last index
  always_comb begin
    if (image_width < bpr_pkg::REG_W'(2)) begin
      w_last = AW'(1);
    end else if (CW'(image_width) > CW'(LINE_DEPTH)) begin
      w_last = AW'(LINE_DEPTH - 1);
    end else begin
      w_last = AW'(image_width - bpr_pkg::REG_W'(1));
    end
    if (image_height < bpr_pkg::REG_W'(2)) begin
      h_last = RW'(1);
    end else if (image_height > bpr_pkg::REG_W'(bpr_pkg::HEIGHT_LIMIT)) begin
      h_last = RW'(bpr_pkg::HEIGHT_LIMIT - 1);
    end else begin
      h_last = RW'(image_height - bpr_pkg::REG_W'(1));
    end
  end

  // an even size has an odd last index and gets a padding row or column
  assign xoff = w_last[0];
  assign yoff = h_last[0];
  assign x    = (column_count < w_last) ? column_count : w_last;
  assign y    = (row_count < h_last) ? row_count : h_last;

  assign credit = {1'b0, q_count} + {{bpr_pkg::QCNT_W{1'b0}}, stage_valid};
  assign full   = (credit >= (bpr_pkg::QCNT_W + 1)'(bpr_pkg::QUEUE_DEPTH));
  assign accept = push && !full;

  always_comb begin
    have_v = 1'b0;
    if (yoff && (y == '0)) begin
      row_op = bpr_pkg::ROW_PAD;
    end else if (y[0] == yoff) begin
      row_op = bpr_pkg::ROW_CLOSE;
      have_v = (y != '0);
    end else begin
      row_op = bpr_pkg::ROW_ADD;
    end
    if (xoff && (x == '0)) begin
      col_op = bpr_pkg::COL_PAD;
    end else if (x[0] == xoff) begin
      col_op = (x == '0) ? bpr_pkg::COL_LEFT : bpr_pkg::COL_EMIT;
    end else begin
      col_op = bpr_pkg::COL_CENTRE;
    end
    is_last = (x == w_last) && (y == h_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      stage_valid  <= 1'b0;
    end else begin
      stage_valid <= accept;
      if (accept) begin
        if (x == w_last) begin
          column_count <= '0;
          row_count    <= (y == h_last) ? '0 : y + 1'b1;
        end else begin
          column_count <= x + 1'b1;
          row_count    <= y;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_pixel  <= pixel_in;
      stage_x      <= x;
      stage_row_op <= row_op;
      stage_have_v <= have_v;
      stage_col_op <= col_op;
      stage_last   <= is_last;
    end
  end

  // line buffer: read at accept, written back in the next cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd <= line_mem[x];
    end
    if (stage_valid) begin
      line_mem[stage_x] <= buf_next;
    end
  end

  assign sum_close = {1'b0, line_rd} + (SW + 1)'(stage_pixel);
  assign sum_add   = {1'b0, line_rd} + (SW + 1)'({stage_pixel, 1'b0});

  always_comb begin
    vsum     = sum_close[SW] ? bpr_pkg::SUM_MAX : sum_close[SW-1:0];
    buf_next = SW'(stage_pixel);
    unique case (stage_row_op)
      bpr_pkg::ROW_PAD:   buf_next = SW'(stage_pixel) + SW'({stage_pixel, 1'b0});
      bpr_pkg::ROW_CLOSE: buf_next = SW'(stage_pixel);
      bpr_pkg::ROW_ADD:   buf_next = sum_add[SW] ? bpr_pkg::SUM_MAX : sum_add[SW-1:0];
      default:            buf_next = SW'(stage_pixel);
    endcase
  end

  assign q_push         = stage_valid && stage_have_v;
  assign q_entry.vsum   = vsum;
  assign q_entry.col_op = stage_col_op;
  assign q_entry.last   = stage_last;

  a_credit: assert property (@(posedge clk) disable iff (rst)
    credit <= (bpr_pkg::QCNT_W + 1)'(bpr_pkg::QUEUE_DEPTH))
    else $error("more items in flight than queue slots");

  a_emit_row: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (stage_row_op == bpr_pkg::ROW_CLOSE))
    else $error("vertical sum pushed from a row that does not close a window");

endmodule

@@ hw/rtl/bpr_back.sv @@
// back part: horizontal [1 2 1] filter, rounding and output register
module bpr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  bpr_pkg::queue_entry_t       q_head,
  output logic                        q_pop,
  output logic                        empty,
  input  logic                        pop,
  output logic [bpr_pkg::PIX_W-1:0]   pixel_out,
  output logic                        frame_last
);

  localparam int SW = bpr_pkg::SUM_W;
  localparam int PW = bpr_pkg::PIX_W;

  logic [SW-1:0]   left_vertical_sum;
  logic [SW-1:0]   centre_vertical_sum;
  logic            out_valid;
  logic            is_emit;
  logic [SW+1:0]   total;
  logic [PW-1:0]   quot;
  logic [3:0]      rem;
  logic            round_up;
  logic [PW:0]     rounded;
  logic [PW-1:0]   pix;

  assign is_emit = (q_head.col_op == bpr_pkg::COL_EMIT);
  assign q_pop   = q_valid && (!is_emit || !out_valid || pop);
  assign empty   = !out_valid;

  assign total = {2'b00, left_vertical_sum} + {1'b0, centre_vertical_sum, 1'b0}
               + {2'b00, q_head.vsum};
  assign quot  = total[SW+1:4];
  assign rem   = total[3:0];
  // round to nearest, ties to even
  assign round_up = (rem > 4'd8) || ((rem == 4'd8) && quot[0]);
  assign rounded  = {1'b0, quot} + (PW + 1)'(round_up);
  assign pix      = rounded[PW] ? {PW{1'b1}} : rounded[PW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      left_vertical_sum   <= '0;
      centre_vertical_sum <= '0;
    end else if (q_pop) begin
      unique case (q_head.col_op)
        bpr_pkg::COL_PAD: begin
          left_vertical_sum   <= q_head.vsum;
          centre_vertical_sum <= q_head.vsum;
        end
        bpr_pkg::COL_LEFT:   left_vertical_sum   <= q_head.vsum;
        bpr_pkg::COL_EMIT:   left_vertical_sum   <= q_head.vsum;
        bpr_pkg::COL_CENTRE: centre_vertical_sum <= q_head.vsum;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && is_emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && is_emit) begin
      pixel_out  <= pix;
      frame_last <= q_head.last;
    end
  end

  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    (q_pop && is_emit && out_valid) |-> pop)
    else $error("output register overwritten before it was taken");

endmodule
